/* rtl/core/signed_int_to_decimal_ascii_top_defines.svh */
// assertion helpers for the top-level rtl file
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// checked on every clock edge outside reset
`define S2DA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every clock edge, reset included
`define S2DA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/core/s2da_pkg.sv */
package s2da_pkg;

   localparam int VALUE_BITS = 32;
   // decimal places needed for the largest magnitude, 2^(VALUE_BITS-1)
   localparam int DIGIT_MAX  = (((VALUE_BITS - 1) * 1233) >> 12) + 1;
   localparam int POS_BITS   = $clog2(DIGIT_MAX);
   localparam int TRIAL_BITS = VALUE_BITS + 4;

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_MINUS = 8'd45;

   typedef logic [DIGIT_MAX-1:0][TRIAL_BITS-1:0] pow_tab_type;

   typedef struct packed {
      logic       push;
      logic [7:0] character;
      logic       last_char;
   } char_req_type;

   function automatic pow_tab_type pow_tab_init();
      pow_tab_type            t;
      logic [TRIAL_BITS-1:0]  p;
      p = TRIAL_BITS'(1);
      for (int k = 0; k < DIGIT_MAX; k++) begin
         t[k] = p;
         p    = p * TRIAL_BITS'(10);
      end
      return t;
   endfunction

   localparam pow_tab_type POW10 = pow_tab_init();

endpackage

/* rtl/core/s2da_cmp_sub.sv */
module s2da_cmp_sub (
   input  logic [s2da_pkg::VALUE_BITS-1:0] rem,
   input  logic [s2da_pkg::TRIAL_BITS-1:0] sub,
   output logic                            ge,
   output logic [s2da_pkg::VALUE_BITS-1:0] diff
);

   logic [s2da_pkg::TRIAL_BITS-1:0] rem_wide;
   logic [s2da_pkg::TRIAL_BITS-1:0] diff_wide;

   assign rem_wide  = s2da_pkg::TRIAL_BITS'(rem);
   assign diff_wide = rem_wide - sub;
   assign ge        = rem_wide >= sub;
   // only used when ge, so the difference fits the magnitude width
   assign diff      = diff_wide[s2da_pkg::VALUE_BITS-1:0];

endmodule

/* rtl/core/s2da_out_reg.sv */
module s2da_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  s2da_pkg::char_req_type char_req,
   output logic                   ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_character,
   output logic                   rsp_last_char
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] char_ff;
   logic       last_ff;

   assign ready    = !valid_ff || !rsp_stall;
   assign valid_in = char_req.push ? 1'b1 : (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (char_req.push) begin
         char_ff <= char_req.character;
         last_ff <= char_req.last_char;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last_char = last_ff;

endmodule

/* rtl/core/signed_int_to_decimal_ascii_top.sv */
// Converts one signed two's complement value per request into its decimal text, sent one
// ASCII character per response in reading order: a '-' for negative values, then the digits
// with no leading zeros, the final character flagged by rsp_last_char. A request is taken only
// while the block is idle. Each request then occupies the block for the sign, if the value is
// negative, and for every decimal place, plus any time the sign or a digit waits because the
// response side stalls with a character still held. The time per place is set by the single
// compare-subtract unit, which settles each of the DIGIT_MAX decimal places by four trial
// subtractions of 8, 4, 2 and 1 times the place's power of ten, most significant place first.
// A one-entry output register lets the next digit be worked while the previous character
// waits to be taken.
`include "signed_int_to_decimal_ascii_top_defines.svh"

module signed_int_to_decimal_ascii_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [s2da_pkg::VALUE_BITS-1:0] req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [7:0]                             rsp_character,
   output logic                                   rsp_last_char
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SIGN = 2'd1;
   localparam logic [1:0] ST_STEP = 2'd2;
   localparam logic [1:0] ST_HOLD = 2'd3;

   logic [1:0]                          state_ff, state_in;
   logic [s2da_pkg::VALUE_BITS-1:0]     rem_ff, rem_in;
   logic [s2da_pkg::POS_BITS-1:0]       pos_ff, pos_in;
   logic [1:0]                          bit_ff, bit_in;
   logic [3:0]                          digit_ff, digit_in;
   logic                                started_ff, started_in;

   logic [s2da_pkg::VALUE_BITS-1:0]     raw;
   logic [s2da_pkg::VALUE_BITS-1:0]     mag;
   logic [s2da_pkg::TRIAL_BITS-1:0]     place;
   logic [s2da_pkg::TRIAL_BITS-1:0]     trial;
   logic [s2da_pkg::TRIAL_BITS-1:0]     rem_bound;
   logic                                ge;
   logic [s2da_pkg::VALUE_BITS-1:0]     diff;
   logic [3:0]                          digit_cur;
   logic                                emit_need;
   logic                                out_ready;
   s2da_pkg::char_req_type              char_req;
   logic                                digit_push;
   logic                                digit_char_ok;
   logic                                rem_in_bound;
   logic                                last_push;

   assign raw       = req_value;
   assign mag       = raw[s2da_pkg::VALUE_BITS-1] ? (~raw + 1'b1) : raw;
   assign place     = s2da_pkg::POW10[pos_ff];
   assign trial     = place << bit_ff;
   assign rem_bound = place << ({1'b0, bit_ff} + 3'd1);
   assign digit_cur = digit_ff | (ge ? (4'b0001 << bit_ff) : 4'b0000);
   assign emit_need = started_ff || (digit_cur != 4'd0) || (pos_ff == '0);
   assign req_stall = state_ff != ST_IDLE;

   s2da_cmp_sub u_cmp_sub (
      .rem  (rem_ff),
      .sub  (trial),
      .ge   (ge),
      .diff (diff)
   );

   s2da_out_reg u_out_reg (
      .clock         (clock),
      .reset         (reset),
      .char_req      (char_req),
      .ready         (out_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last_char (rsp_last_char)
   );

   always_comb begin
      state_in   = state_ff;
      rem_in     = rem_ff;
      pos_in     = pos_ff;
      bit_in     = bit_ff;
      digit_in   = digit_ff;
      started_in = started_ff;
      char_req   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rem_in     = mag;
               pos_in     = s2da_pkg::POS_BITS'(s2da_pkg::DIGIT_MAX - 1);
               bit_in     = 2'd3;
               digit_in   = 4'd0;
               started_in = 1'b0;
               state_in   = raw[s2da_pkg::VALUE_BITS-1] ? ST_SIGN : ST_STEP;
            end
         end
         ST_SIGN: begin
            if (out_ready) begin
               char_req.push      = 1'b1;
               char_req.character = s2da_pkg::CHAR_MINUS;
               char_req.last_char = 1'b0;
               state_in           = ST_STEP;
            end
         end
         ST_STEP: begin
            if (ge) begin
               rem_in = diff;
            end
            digit_in = digit_cur;
            if (bit_ff != 2'd0) begin
               bit_in = bit_ff - 2'd1;
            end else if (emit_need && !out_ready) begin
               state_in = ST_HOLD;
            end else begin
               if (emit_need) begin
                  char_req.push      = 1'b1;
                  char_req.character = s2da_pkg::CHAR_ZERO + {4'd0, digit_cur};
                  char_req.last_char = pos_ff == '0;
                  started_in         = 1'b1;
               end
               if (pos_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  pos_in   = pos_ff - 1'b1;
                  bit_in   = 2'd3;
                  digit_in = 4'd0;
               end
            end
         end
         ST_HOLD: begin
            // digit done, waiting for room in the output register
            if (out_ready) begin
               char_req.push      = 1'b1;
               char_req.character = s2da_pkg::CHAR_ZERO + {4'd0, digit_ff};
               char_req.last_char = pos_ff == '0;
               started_in         = 1'b1;
               if (pos_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  pos_in   = pos_ff - 1'b1;
                  bit_in   = 2'd3;
                  digit_in = 4'd0;
                  state_in = ST_STEP;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      pos_ff     <= pos_in;
      bit_ff     <= bit_in;
      digit_ff   <= digit_in;
      started_ff <= started_in;
   end

   assign digit_push    = char_req.push && (state_ff != ST_SIGN);
   assign digit_char_ok = (char_req.character >= s2da_pkg::CHAR_ZERO) &&
                          (char_req.character <= (s2da_pkg::CHAR_ZERO + 8'd9));
   assign rem_in_bound  = s2da_pkg::TRIAL_BITS'(rem_ff) < rem_bound;
   assign last_push     = char_req.push && char_req.last_char;

   `S2DA_ASSERT(a_push_has_room, char_req.push |-> out_ready, "push into a full output register")
   `S2DA_ASSERT(a_digit_range, digit_push |-> digit_char_ok, "digit character out of range")
   `S2DA_ASSERT(a_rem_bound, (state_ff == ST_STEP) |-> rem_in_bound, "remainder out of bound")
   `S2DA_ASSERT(a_last_ends_run, last_push |=> (state_ff == ST_IDLE), "run did not end")

endmodule
